@@ hdl/rmie_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmie_pkg
// Shared constants, codes, types and index helpers of the register machine
// instruction executor.
// ----------------------------------------------------------------------------
package rmie_pkg;

	localparam int REG_COUNT  = 256;
	localparam int JUMP_SLOTS = 256;
	localparam int DATA_WIDTH = 32;
	localparam int PC_WIDTH   = 16;
	localparam int PRINT_W    = 32;

	localparam int RF_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int JT_AW = (JUMP_SLOTS > 1) ? $clog2(JUMP_SLOTS) : 1;

	// ceil(2^16 / n): exact quotient of a byte by n after >> 16
	localparam int RF_RECIP = (65536 + REG_COUNT - 1) / REG_COUNT;
	localparam int JT_RECIP = (65536 + JUMP_SLOTS - 1) / JUMP_SLOTS;

	typedef enum logic [7:0] {
		OP_LOAD  = 8'd0,
		OP_JMP   = 8'd1,
		OP_PRN   = 8'd2,
		OP_PRC   = 8'd3,
		OP_SWAP  = 8'd4,
		OP_ADD   = 8'd5,
		OP_SUB   = 8'd6,
		OP_MUL   = 8'd7,
		OP_END   = 8'd8,
		OP_JEQ   = 8'd9,
		OP_JGT   = 8'd10,
		OP_NOP   = 8'd11,
		OP_ISWAP = 8'd12,
		OP_NL    = 8'd13,
		OP_DEFJ  = 8'd14,
		OP_ADDI  = 8'd15,
		OP_SUBI  = 8'd16,
		OP_MULI  = 8'd17,
		OP_COPY  = 8'd18,
		OP_JEQI  = 8'd19,
		OP_JGTI  = 8'd20
	} op_t;

	typedef enum logic [1:0] {
		PK_NONE = 2'd0,
		PK_DEC  = 2'd1,
		PK_CHR  = 2'd2,
		PK_NL   = 2'd3
	} pk_t;

	typedef enum logic [2:0] {
		PH_READ,
		PH_EXEC,
		PH_MUL,
		PH_IND,
		PH_SWAP
	} ph_t;

	typedef struct packed {
		logic             re;
		logic [RF_AW-1:0] addr_a;
		logic [RF_AW-1:0] addr_b;
	} rf_rd_t;

	typedef struct packed {
		logic                  we;
		logic [RF_AW-1:0]      addr;
		logic [DATA_WIDTH-1:0] data;
	} rf_wr_t;

	function automatic logic [8:0] byte_mod(input logic [7:0] x, input logic [12:0] recip,
			input logic [8:0] cnt);
		logic [20:0] prod;
		logic [4:0]  q;
		logic [8:0]  rem;
		prod = 21'(x) * 21'(recip);
		q    = prod[20:16];
		rem  = 9'(x) - 9'(9'(q) * cnt);
		if (rem >= cnt) begin
			rem = rem - cnt;
		end
		return rem;
	endfunction

	function automatic logic [RF_AW-1:0] reg_idx(input logic [7:0] x);
		logic [8:0] r;
		r = byte_mod(x, 13'(RF_RECIP), 9'(REG_COUNT));
		return r[RF_AW-1:0];
	endfunction

	function automatic logic [JT_AW-1:0] jmp_idx(input logic [7:0] x);
		logic [8:0] r;
		r = byte_mod(x, 13'(JT_RECIP), 9'(JUMP_SLOTS));
		return r[JT_AW-1:0];
	endfunction

	function automatic logic [PRINT_W-1:0] to_print(input logic [DATA_WIDTH-1:0] v);
		logic signed [63:0] w;
		w = 64'($signed(v));
		return w[PRINT_W-1:0];
	endfunction

endpackage

@@ hdl/register_machine_instruction_executor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_instruction_executor
// Executes one register machine instruction per beat against a register
// file, a jump table and a program counter; one result beat per input beat.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    action, opcode, field_a, field_b, field_c
// out      out  out_valid / out_ready  next_pc, halted, print_kind, print_value
//
// Phases: operand read, execute; multiply adds a product phase, swap a second
// write phase and indirect swap an indirect phase before it (one write port).
// A one-beat input buffer accepts the next beat while one executes; a result
// register decouples the output side. Output stall holds the final cycle.
// Reset clears the program counter and the valid bits of both memories; no
// clearing pass, the block is ready right after reset.
// ----------------------------------------------------------------------------
module register_machine_instruction_executor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [7:0]                    opcode,
	input  logic [7:0]                    field_a,
	input  logic [7:0]                    field_b,
	input  logic [7:0]                    field_c,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rmie_pkg::PC_WIDTH-1:0] next_pc,
	output logic                          halted,
	output logic [1:0]                    print_kind,
	output logic signed [rmie_pkg::PRINT_W-1:0] print_value
);
	import rmie_pkg::*;

	// input buffer
	logic       ib_vld_q;
	logic       ib_act_q;
	logic [7:0] ib_op_q;
	logic [7:0] ib_a_q;
	logic [7:0] ib_b_q;
	logic [7:0] ib_c_q;

	// instruction in flight
	logic       act_q;
	op_t        op_q;
	logic [7:0] fa_q;
	logic [7:0] fb_q;
	logic [7:0] fc_q;

	ph_t ph_q;
	ph_t ph_d;

	logic [PC_WIDTH-1:0]   pc_q;
	logic [PC_WIDTH-1:0]   pc_inc;
	logic [DATA_WIDTH-1:0] mul_s1;
	logic [RF_AW-1:0]      x_q;
	logic [RF_AW-1:0]      wb_addr_q;
	logic [RF_AW-1:0]      x_d;
	logic [RF_AW-1:0]      wb_addr_d;
	logic                  ld_wb;

	rf_rd_t                rf_rd;
	rf_wr_t                rf_wr;
	logic [DATA_WIDTH-1:0] ra;
	logic [DATA_WIDTH-1:0] rb;
	logic [DATA_WIDTH-1:0] fb_ext;

	// jump table
	logic [PC_WIDTH-1:0]   jt_mem [JUMP_SLOTS];
	logic [JUMP_SLOTS-1:0] jt_vld_q;
	logic [PC_WIDTH-1:0]   jt_dout_q;
	logic                  jt_v_s1;
	logic [PC_WIDTH-1:0]   jt_rd;
	logic                  jt_re;
	logic [JT_AW-1:0]      jt_raddr;
	logic                  jt_we;
	logic [JT_AW-1:0]      jt_waddr;
	logic [PC_WIDTH-1:0]   jt_wdata;

	logic take;
	logic out_free;
	logic fin;

	logic [PC_WIDTH-1:0] res_pc;
	logic                res_halt;
	pk_t                 res_kind;
	logic [PRINT_W-1:0]  res_val;

	logic                out_vld_q;
	logic [PC_WIDTH-1:0] out_pc_q;
	logic                out_halt_q;
	pk_t                 out_kind_q;
	logic [PRINT_W-1:0]  out_val_q;

	assign take     = (ph_q == PH_READ) && ib_vld_q;
	assign in_ready = !ib_vld_q || take;
	assign out_free = !out_vld_q || out_ready;
	assign pc_inc   = pc_q + PC_WIDTH'(1);
	assign fb_ext   = DATA_WIDTH'(fb_q);
	assign jt_rd    = jt_v_s1 ? jt_dout_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ib_vld_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			ib_vld_q <= 1'b1;
		end else if (take) begin
			ib_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ib_act_q <= action;
			ib_op_q  <= opcode;
			ib_a_q   <= field_a;
			ib_b_q   <= field_b;
			ib_c_q   <= field_c;
		end
		if (take) begin
			act_q <= ib_act_q;
			op_q  <= op_t'(ib_op_q);
			fa_q  <= ib_a_q;
			fb_q  <= ib_b_q;
			fc_q  <= ib_c_q;
		end
		if (ph_q == PH_EXEC) begin
			mul_s1 <= ra * ((op_q == OP_MUL) ? rb : fb_ext);
		end
		if (ld_wb) begin
			x_q       <= x_d;
			wb_addr_q <= wb_addr_d;
		end
	end

	rmie_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rf_rd),
		.wr     (rf_wr),
		.rd_a   (ra),
		.rd_b   (rb)
	);

	always_ff @(posedge clk) begin
		if (jt_we) begin
			jt_mem[jt_waddr] <= jt_wdata;
		end
		if (jt_re) begin
			jt_dout_q <= jt_mem[jt_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jt_vld_q <= '0;
			jt_v_s1  <= 1'b0;
		end else begin
			if (jt_we) begin
				jt_vld_q[jt_waddr] <= 1'b1;
			end
			if (jt_re) begin
				jt_v_s1 <= jt_vld_q[jt_raddr];
			end
		end
	end

	always_comb begin
		ph_d = ph_q;
		case (ph_q)
			PH_READ: begin
				if (ib_vld_q) begin
					ph_d = PH_EXEC;
				end
			end
			PH_EXEC: begin
				if (act_q && (op_q == OP_MUL || op_q == OP_MULI)) begin
					ph_d = PH_MUL;
				end else if (act_q && op_q == OP_SWAP) begin
					ph_d = PH_SWAP;
				end else if (act_q && op_q == OP_ISWAP) begin
					ph_d = PH_IND;
				end else if (out_free) begin
					ph_d = PH_READ;
				end
			end
			PH_MUL: begin
				if (out_free) begin
					ph_d = PH_READ;
				end
			end
			PH_IND: begin
				ph_d = PH_SWAP;
			end
			PH_SWAP: begin
				if (out_free) begin
					ph_d = PH_READ;
				end
			end
			default: begin
				ph_d = PH_READ;
			end
		endcase
	end

	always_comb begin
		rf_rd.re     = 1'b0;
		rf_rd.addr_a = reg_idx(ib_a_q);
		rf_rd.addr_b = reg_idx(ib_b_q);
		rf_wr.we     = 1'b0;
		rf_wr.addr   = reg_idx(fc_q);
		rf_wr.data   = ra;
		jt_re        = 1'b0;
		jt_raddr     = (ib_op_q == OP_JMP) ? jmp_idx(ib_a_q) : jmp_idx(ib_c_q);
		jt_we        = 1'b0;
		jt_waddr     = jmp_idx(fa_q);
		jt_wdata     = {fb_q, fc_q};
		ld_wb        = 1'b0;
		x_d          = reg_idx(ra[7:0]);
		wb_addr_d    = reg_idx(fb_q);
		fin          = 1'b0;
		res_pc       = pc_q;
		res_halt     = 1'b0;
		res_kind     = PK_NONE;
		res_val      = '0;
		case (ph_q)
			PH_READ: begin
				rf_rd.re = ib_vld_q;
				jt_re    = ib_vld_q;
			end
			PH_EXEC: begin
				if (!act_q) begin
					fin   = out_free;
					jt_we = out_free && (op_q == OP_DEFJ);
				end else begin
					res_pc = pc_inc;
					case (op_q)
						OP_LOAD: begin
							fin        = out_free;
							rf_wr.we   = out_free;
							rf_wr.addr = reg_idx(fa_q);
							rf_wr.data = DATA_WIDTH'({fb_q, fc_q});
						end
						OP_JMP: begin
							fin    = out_free;
							res_pc = jt_rd;
						end
						OP_PRN: begin
							fin      = out_free;
							res_kind = PK_DEC;
							res_val  = to_print(ra);
						end
						OP_PRC: begin
							fin      = out_free;
							res_kind = PK_CHR;
							res_val  = to_print(ra);
						end
						OP_SWAP: begin
							rf_wr.we   = 1'b1;
							rf_wr.addr = reg_idx(fa_q);
							rf_wr.data = rb;
							ld_wb      = 1'b1;
						end
						OP_ADD: begin
							fin        = out_free;
							rf_wr.we   = out_free;
							rf_wr.data = ra + rb;
						end
						OP_SUB: begin
							fin        = out_free;
							rf_wr.we   = out_free;
							rf_wr.data = ra - rb;
						end
						OP_ADDI: begin
							fin        = out_free;
							rf_wr.we   = out_free;
							rf_wr.data = ra + fb_ext;
						end
						OP_SUBI: begin
							fin        = out_free;
							rf_wr.we   = out_free;
							rf_wr.data = ra - fb_ext;
						end
						OP_MUL, OP_MULI: begin
							fin = 1'b0;
						end
						OP_END: begin
							fin      = out_free;
							res_pc   = pc_q;
							res_halt = 1'b1;
						end
						OP_JEQ: begin
							fin    = out_free;
							res_pc = (ra == rb) ? jt_rd : pc_inc;
						end
						OP_JGT: begin
							fin    = out_free;
							res_pc = ($signed(ra) > $signed(rb)) ? jt_rd : pc_inc;
						end
						OP_JEQI: begin
							fin    = out_free;
							res_pc = (ra == fb_ext) ? jt_rd : pc_inc;
						end
						OP_JGTI: begin
							fin    = out_free;
							res_pc = ($signed(ra) > $signed(fb_ext)) ? jt_rd : pc_inc;
						end
						OP_NOP: begin
							fin = out_free;
						end
						OP_NL: begin
							fin      = out_free;
							res_kind = PK_NL;
						end
						OP_ISWAP: begin
							rf_rd.re     = 1'b1;
							rf_rd.addr_a = reg_idx(ra[7:0]);
							rf_rd.addr_b = reg_idx(rb[7:0]);
							ld_wb        = 1'b1;
							wb_addr_d    = reg_idx(rb[7:0]);
						end
						OP_DEFJ: begin
							fin   = out_free;
							jt_we = out_free;
						end
						OP_COPY: begin
							fin        = out_free;
							rf_wr.we   = out_free;
							rf_wr.addr = reg_idx(fb_q);
						end
						default: begin
							fin    = out_free;
							res_pc = pc_q;
						end
					endcase
				end
			end
			PH_MUL: begin
				fin        = out_free;
				rf_wr.we   = out_free;
				rf_wr.data = mul_s1;
				res_pc     = pc_inc;
			end
			PH_IND: begin
				rf_wr.we   = 1'b1;
				rf_wr.addr = x_q;
				rf_wr.data = rb;
			end
			PH_SWAP: begin
				fin        = out_free;
				rf_wr.we   = out_free;
				rf_wr.addr = wb_addr_q;
				rf_wr.data = ra;
				res_pc     = pc_inc;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_READ;
			pc_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			ph_q <= ph_d;
			if (fin && act_q) begin
				pc_q <= res_pc;
			end
			if (fin) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_pc_q   <= res_pc;
			out_halt_q <= res_halt;
			out_kind_q <= res_kind;
			out_val_q  <= res_val;
		end
	end

	assign out_valid   = out_vld_q;
	assign next_pc     = out_pc_q;
	assign halted      = out_halt_q;
	assign print_kind  = out_kind_q;
	assign print_value = $signed(out_val_q);

endmodule

@@ hdl/rmie_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmie_regfile
// Register file: two registered read ports, one write port. Entries never
// written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module rmie_regfile (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rmie_pkg::rf_rd_t                 rd,
	input  rmie_pkg::rf_wr_t                 wr,
	output logic [rmie_pkg::DATA_WIDTH-1:0]  rd_a,
	output logic [rmie_pkg::DATA_WIDTH-1:0]  rd_b
);
	import rmie_pkg::*;

	logic [DATA_WIDTH-1:0] mem [REG_COUNT];
	logic [REG_COUNT-1:0]  vld_q;
	logic [DATA_WIDTH-1:0] dout_a_q;
	logic [DATA_WIDTH-1:0] dout_b_q;
	logic                  va_q;
	logic                  vb_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.re) begin
			dout_a_q <= mem[rd.addr_a];
			dout_b_q <= mem[rd.addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			va_q  <= 1'b0;
			vb_q  <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.re) begin
				va_q <= vld_q[rd.addr_a];
				vb_q <= vld_q[rd.addr_b];
			end
		end
	end

	assign rd_a = va_q ? dout_a_q : '0;
	assign rd_b = vb_q ? dout_b_q : '0;

endmodule

@@ sim/register_machine_instruction_executor_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_machine_instruction_executor_tb
// Self-checking bench for the register machine executor. A directed table
// covers reset state, field extremes, all opcodes but SUB, ADDI and JGTI,
// an unknown opcode, halt, prescan, PC wrap, self swap and indirect swap. A
// random program with a small hot register set follows. A local machine
// model predicts each result beat; random gaps throttle input and output.
// ----------------------------------------------------------------------------
module register_machine_instruction_executor_tb;
	import rmie_pkg::*;

	localparam int NREG   = REG_COUNT;
	localparam int NJMP   = JUMP_SLOTS;
	localparam int RAND_N = 1625;

	typedef struct packed {
		logic       act;
		logic [7:0] op;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} beat_t;

	typedef struct packed {
		logic [15:0] pc;
		logic        halt;
		pk_t         kind;
		logic [31:0] val;
	} result_t;

	typedef struct packed {
		beat_t   in;
		logic    fixed;
		result_t res;
	} dir_row_t;

	localparam result_t NO_RES = '0;
	localparam int DIR_N = 26;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		'{'{1'b1, OP_NOP,   8'h00, 8'h00, 8'h00}, 1'b1, '{16'h0001, 1'b0, PK_NONE, 32'h0}},
		'{'{1'b1, OP_PRN,   8'h00, 8'h00, 8'h00}, 1'b1, '{16'h0002, 1'b0, PK_DEC,  32'h0}},
		'{'{1'b1, OP_NL,    8'hFF, 8'hFF, 8'hFF}, 1'b1, '{16'h0003, 1'b0, PK_NL,   32'h0}},
		'{'{1'b1, 8'hFF,    8'hFF, 8'hFF, 8'hFF}, 1'b1, '{16'h0003, 1'b0, PK_NONE, 32'h0}},
		'{'{1'b1, OP_END,   8'h00, 8'h00, 8'h00}, 1'b1, '{16'h0003, 1'b1, PK_NONE, 32'h0}},
		'{'{1'b0, OP_NOP,   8'h00, 8'h00, 8'h00}, 1'b1, '{16'h0003, 1'b0, PK_NONE, 32'h0}},
		'{'{1'b0, OP_DEFJ,  8'hFF, 8'hFF, 8'hFF}, 1'b1, '{16'h0003, 1'b0, PK_NONE, 32'h0}},
		'{'{1'b1, OP_JMP,   8'hFF, 8'h00, 8'h00}, 1'b1, '{16'hFFFF, 1'b0, PK_NONE, 32'h0}},
		'{'{1'b1, OP_NOP,   8'h00, 8'h00, 8'h00}, 1'b1, '{16'h0000, 1'b0, PK_NONE, 32'h0}},
		'{'{1'b1, OP_LOAD,  8'hFF, 8'hFF, 8'hFF}, 1'b1, '{16'h0001, 1'b0, PK_NONE, 32'h0}},
		'{'{1'b1, OP_PRN,   8'hFF, 8'h00, 8'h00}, 1'b1,
			'{16'h0002, 1'b0, PK_DEC, 32'h0000FFFF}},
		'{'{1'b1, OP_LOAD,  8'h01, 8'h80, 8'h00}, 1'b0, NO_RES},
		'{'{1'b1, OP_MUL,   8'h01, 8'h01, 8'h04}, 1'b0, NO_RES},
		'{'{1'b1, OP_ADD,   8'h04, 8'h04, 8'h05}, 1'b0, NO_RES},
		'{'{1'b1, OP_SUBI,  8'h05, 8'h01, 8'h06}, 1'b0, NO_RES},
		'{'{1'b1, OP_PRN,   8'h05, 8'h00, 8'h00}, 1'b0, NO_RES},
		'{'{1'b1, OP_DEFJ,  8'h07, 8'h12, 8'h34}, 1'b0, NO_RES},
		'{'{1'b1, OP_JGT,   8'h06, 8'h05, 8'h07}, 1'b0, NO_RES},
		'{'{1'b1, OP_MULI,  8'hFF, 8'hFF, 8'h07}, 1'b0, NO_RES},
		'{'{1'b1, OP_SWAP,  8'h05, 8'h06, 8'h00}, 1'b0, NO_RES},
		'{'{1'b1, OP_SWAP,  8'h02, 8'h02, 8'h00}, 1'b0, NO_RES},
		'{'{1'b1, OP_ISWAP, 8'hFF, 8'h01, 8'h00}, 1'b0, NO_RES},
		'{'{1'b1, OP_COPY,  8'h07, 8'h08, 8'h00}, 1'b0, NO_RES},
		'{'{1'b1, OP_JEQ,   8'h07, 8'h08, 8'h07}, 1'b0, NO_RES},
		'{'{1'b1, OP_JEQI,  8'h03, 8'h00, 8'h07}, 1'b0, NO_RES},
		'{'{1'b1, OP_PRC,   8'h06, 8'h00, 8'h00}, 1'b0, NO_RES}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = 1'b0;
	logic [7:0]  opcode = 8'h00;
	logic [7:0]  field_a = 8'h00;
	logic [7:0]  field_b = 8'h00;
	logic [7:0]  field_c = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [PC_WIDTH-1:0]       next_pc;
	logic                      halted;
	logic [1:0]                print_kind;
	logic signed [PRINT_W-1:0] print_value;

	logic [31:0] regs [NREG];
	logic [15:0] jtab [NJMP];
	logic [15:0] prog_pc;

	result_t pending [$];
	result_t mon_want;
	int      errors = 0;
	int      hold_left = 0;
	bit      steady = 1'b0;

	register_machine_instruction_executor u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.opcode      (opcode),
		.field_a     (field_a),
		.field_b     (field_b),
		.field_c     (field_c),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.next_pc     (next_pc),
		.halted      (halted),
		.print_kind  (print_kind),
		.print_value (print_value)
	);

	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic result_t run_instr(input beat_t s);
		result_t     r;
		logic [15:0] imm, inc, pc, tc;
		logic [31:0] ra, rb, vx, vy;
		int          ix, iy;
		r   = '0;
		imm = {s.b, s.c};
		pc  = prog_pc;
		inc = pc + 16'd1;
		ra  = regs[s.a % NREG];
		rb  = regs[s.b % NREG];
		tc  = jtab[s.c % NJMP];
		if (!s.act) begin
			if (s.op == OP_DEFJ) begin
				jtab[s.a % NJMP] = imm;
			end
		end else begin
			case (s.op)
				OP_LOAD: begin regs[s.a % NREG] = {16'h0, imm}; pc = inc; end
				OP_JMP:  pc = jtab[s.a % NJMP];
				OP_PRN: begin r.kind = PK_DEC; r.val = ra; pc = inc; end
				OP_PRC: begin r.kind = PK_CHR; r.val = ra; pc = inc; end
				OP_SWAP: begin
					regs[s.a % NREG] = rb;
					regs[s.b % NREG] = ra;
					pc = inc;
				end
				OP_ADD: begin regs[s.c % NREG] = ra + rb; pc = inc; end
				OP_SUB: begin regs[s.c % NREG] = ra - rb; pc = inc; end
				OP_MUL: begin regs[s.c % NREG] = ra * rb; pc = inc; end
				OP_END:  r.halt = 1'b1;
				OP_JEQ:  pc = (ra == rb) ? tc : inc;
				OP_JGT:  pc = ($signed(ra) > $signed(rb)) ? tc : inc;
				OP_NOP:  pc = inc;
				OP_ISWAP: begin
					ix = ra[7:0] % NREG;
					iy = rb[7:0] % NREG;
					vx = regs[ix];
					vy = regs[iy];
					regs[ix] = vy;
					regs[iy] = vx;
					pc = inc;
				end
				OP_NL: begin r.kind = PK_NL; pc = inc; end
				OP_DEFJ: begin jtab[s.a % NJMP] = imm; pc = inc; end
				OP_ADDI: begin regs[s.c % NREG] = ra + {24'h0, s.b}; pc = inc; end
				OP_SUBI: begin regs[s.c % NREG] = ra - {24'h0, s.b}; pc = inc; end
				OP_MULI: begin regs[s.c % NREG] = ra * {24'h0, s.b}; pc = inc; end
				OP_COPY: begin regs[s.b % NREG] = ra; pc = inc; end
				OP_JEQI: pc = (ra == {24'h0, s.b}) ? tc : inc;
				OP_JGTI: pc = ($signed(ra) > $signed({24'h0, s.b})) ? tc : inc;
				default: ;
			endcase
			prog_pc = pc;
		end
		r.pc = prog_pc;
		return r;
	endfunction

	function automatic logic [7:0] pick_reg();
		return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_imm();
		case ($urandom_range(0, 3))
			0:       return 8'($urandom_range(0, 3));
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic beat_t rand_beat();
		beat_t s;
		s.act = ($urandom_range(0, 99) >= 6);
		if (!s.act && $urandom_range(0, 9) < 6) begin
			s.op = OP_DEFJ;
		end else if ($urandom_range(0, 19) == 0) begin
			s.op = 8'($urandom_range(21, 255));
		end else begin
			s.op = 8'($urandom_range(0, 20));
		end
		s.a = pick_reg();
		case (s.op)
			OP_LOAD, OP_DEFJ, OP_ADDI, OP_SUBI, OP_MULI, OP_JEQI, OP_JGTI: s.b = pick_imm();
			default: s.b = pick_reg();
		endcase
		s.c = (s.op == OP_LOAD || s.op == OP_DEFJ) ? 8'($urandom_range(0, 255)) : pick_reg();
		return s;
	endfunction

	function automatic int sender_gap();
		int unsigned r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(input beat_t s, input logic fixed, input result_t lit);
		result_t r;
		in_valid <= 1'b1;
		action   <= s.act;
		opcode   <= s.op;
		field_a  <= s.a;
		field_b  <= s.b;
		field_c  <= s.c;
		do @(posedge clk); while (!in_ready);
		r = run_instr(s);
		pending.push_back(fixed ? lit : r);
	endtask

	task automatic pause_sender(input bit drain);
		int gap;
		gap = sender_gap();
		if (gap > 0 || drain) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (drain && pending.size() != 0) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (steady || $urandom_range(0, 99) < 65) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= 1'b0;
			hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("unexpected result beat: next_pc=%h", next_pc);
				errors++;
			end else begin
				mon_want = pending.pop_front();
				if (next_pc !== mon_want.pc) begin
					$error("next_pc: expected %h, got %h", mon_want.pc, next_pc);
					errors++;
				end
				if (halted !== mon_want.halt) begin
					$error("halted: expected %b, got %b", mon_want.halt, halted);
					errors++;
				end
				if (print_kind !== mon_want.kind) begin
					$error("print_kind: expected %0d, got %0d", mon_want.kind, print_kind);
					errors++;
				end
				if (print_value !== mon_want.val) begin
					$error("print_value: expected %h, got %h", mon_want.val, print_value);
					errors++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < NREG; i++) begin
			regs[i] = '0;
		end
		for (int i = 0; i < NJMP; i++) begin
			jtab[i] = '0;
		end
		prog_pc = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send_beat(DIR_TAB[i].in, DIR_TAB[i].fixed, DIR_TAB[i].res);
			pause_sender(1'b0);
		end

		for (int i = 0; i < RAND_N; i++) begin
			if (i % 200 == 100) begin
				steady = 1'b1;
			end else if (i % 200 == 160) begin
				steady = 1'b0;
			end
			send_beat(rand_beat(), 1'b0, NO_RES);
			pause_sender(i == RAND_N / 2);
		end
		in_valid <= 1'b0;

		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/rmie_pkg.sv
hdl/rmie_regfile.sv
hdl/register_machine_instruction_executor.sv
sim/register_machine_instruction_executor_tb.sv
